@@ rtl/lom_pkg.sv @@
// Package for the layer order manager: sizes, operation and status codes,
// and the control word broadcast along the chain of list cells.
// No dependencies.
`default_nettype none

package lom_pkg;

    localparam int NCH  = 16;               // number of input channels
    localparam int CW   = 4;                // width of a channel id
    localparam int IDXW = $clog2(NCH);      // width of a list position index
    localparam int CNTW = $clog2(NCH + 1);  // width of the list length

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_UP     = 3'd2,
        OP_DOWN   = 3'd3,
        OP_TOP    = 3'd4,
        OP_BOTTOM = 3'd5,
        OP_READ   = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_ID  = 2'd1,
        STAT_NO_IDLE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Control word seen by every cell of the list.
    typedef struct packed {
        logic            en;        // commit the update this cycle
        logic [2:0]      op;        // operation code
        logic            found;     // channel was found in the list
        logic            alloc_ok;  // allocate succeeded
        logic [CNTW-1:0] pos;       // position where the channel was found
        logic [CNTW-1:0] cnt;       // list length before the update
        logic [CW-1:0]   ch;        // channel searched for
        logic [CW-1:0]   ld_val;    // id written into a slot by a load
    } t_bcast;

endpackage

`default_nettype wire

@@ rtl/lom_cell.sv @@
// One slot of the layer list: holds a channel id and takes a new value from
// itself, a neighbour or the broadcast load value. Depends on lom_pkg.
`default_nettype none

module lom_cell (
    input  wire logic                    i_clk,
    input  wire lom_pkg::t_bcast         i_bc,
    input  wire logic [lom_pkg::CNTW-1:0] i_index,
    input  wire logic [lom_pkg::CW-1:0]  i_below,
    input  wire logic [lom_pkg::CW-1:0]  i_above,
    output logic      [lom_pkg::CW-1:0]  o_slot,
    output logic                         o_match
);
    import lom_pkg::*;

    logic [CW-1:0]   r_slot;
    logic [CW-1:0]   n_slot;
    logic [CNTW-1:0] w_next_idx;
    logic [CNTW-1:0] w_next_pos;

    assign w_next_idx = i_index + CNTW'(1);
    assign w_next_pos = i_bc.pos + CNTW'(1);

    always_comb begin
        n_slot = r_slot;
        unique case (i_bc.op)
            OP_ALLOC: begin
                if (i_bc.alloc_ok && i_index == i_bc.cnt) begin
                    n_slot = i_bc.ld_val;
                end
            end
            OP_FREE: begin
                if (i_bc.found && i_index >= i_bc.pos && w_next_idx < i_bc.cnt) begin
                    n_slot = i_above;
                end
            end
            OP_UP: begin
                if (i_bc.found && w_next_pos < i_bc.cnt) begin
                    if (i_index == i_bc.pos) begin
                        n_slot = i_above;
                    end else if (i_index == w_next_pos) begin
                        n_slot = i_below;
                    end
                end
            end
            OP_DOWN: begin
                if (i_bc.found && i_bc.pos != '0) begin
                    if (w_next_idx == i_bc.pos) begin
                        n_slot = i_above;
                    end else if (i_index == i_bc.pos) begin
                        n_slot = i_below;
                    end
                end
            end
            OP_TOP: begin
                if (i_bc.found) begin
                    if (w_next_idx == i_bc.cnt) begin
                        n_slot = i_bc.ld_val;
                    end else if (i_index >= i_bc.pos && w_next_idx < i_bc.cnt) begin
                        n_slot = i_above;
                    end
                end
            end
            OP_BOTTOM: begin
                if (i_bc.found) begin
                    if (i_index == '0) begin
                        n_slot = i_bc.ld_val;
                    end else if (i_index <= i_bc.pos) begin
                        n_slot = i_below;
                    end
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    // Slot contents are undefined until first written, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_bc.en) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot  = r_slot;
    assign o_match = (r_slot == i_bc.ch) && (i_index < i_bc.cnt);

endmodule

`default_nettype wire

@@ rtl/layer_order_manager.sv @@
// Top level of the layer order manager: request register, control sequencer,
// channel busy flags, the chain of list cells and the result register.
// Depends on lom_pkg and lom_cell.
//
// Usage. Commands arrive as transactions on the input channel (i_valid,
// o_ready, with i_op, i_channel and i_position) and every command produces
// exactly one result transaction on the output channel (o_valid, i_ready,
// with o_status, o_channel_out, o_entry_valid and o_layer_count).
// The layer list is a row of sixteen cells, cell 0 being the bottom layer.
// Each cell compares its own id against the requested channel, and on an
// update takes its value from itself, from the cell above, from the cell
// below or from the broadcast load value.
// Sequence: a command is registered in the cycle it is accepted, and in the
// execute state that follows, the cells search, shift and commit while the
// result is written into the output register. No new command is accepted
// until the current one has committed and the block is back in idle.
// The result register decouples the two sides: a result still waiting to be
// taken does not stop the next command being accepted, but a command cannot
// complete while the previous result is still held, so a stalled receiver
// holds the block in its execute state until the result slot frees.
// Reset (i_rst_n low, synchronous) empties the list, marks every channel
// idle and drops any pending result. The list slots themselves are not
// cleared; only positions below the list length are ever read.
`default_nettype none

module layer_order_manager (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_op,
    input  wire logic [3:0] i_channel,
    input  wire logic [3:0] i_position,
    // result channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [3:0]      o_channel_out,
    output logic            o_entry_valid,
    output logic [4:0]      o_layer_count
);
    import lom_pkg::*;

    // Sequencer and command registers.
    t_state          r_state;
    t_state          n_state;
    logic [2:0]      r_op;
    logic [CW-1:0]   r_ch;
    logic [CW-1:0]   r_pos;

    // Block state kept outside the cells.
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic [NCH-1:0]  r_busy;
    logic [NCH-1:0]  n_busy;

    // Result register.
    logic            r_o_valid;
    logic [1:0]      r_o_status;
    logic [CW-1:0]   r_o_chan;
    logic            r_o_ev;
    logic [CNTW-1:0] r_o_cnt;

    // Cell row connections.
    logic [CW-1:0]   w_slot [NCH];
    logic [NCH-1:0]  w_match;
    t_bcast          w_bc;

    // Search results and the outcome of the current command.
    logic            w_found;
    logic [CNTW-1:0] w_fpos;
    logic            w_idle_found;
    logic [IDXW-1:0] w_idle_id;
    logic            w_alloc_ok;
    logic [1:0]      w_status;
    logic [CW-1:0]   w_chan;
    logic            w_ev;
    logic [CW-1:0]   w_ld_val;
    logic            w_out_free;
    logic            w_commit;
    logic            w_accept;

    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;

    always_comb begin
        n_state  = r_state;
        w_commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_op;
            r_ch  <= i_channel;
            r_pos <= i_position;
        end
    end

    // Lowest listed position holding the requested channel.
    always_comb begin
        w_found = 1'b0;
        w_fpos  = '0;
        for (int k = NCH - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_found = 1'b1;
                w_fpos  = CNTW'(k);
            end
        end
    end

    // Lowest idle channel.
    always_comb begin
        w_idle_found = 1'b0;
        w_idle_id    = '0;
        for (int k = NCH - 1; k >= 0; k--) begin
            if (!r_busy[k]) begin
                w_idle_found = 1'b1;
                w_idle_id    = IDXW'(k);
            end
        end
    end

    // Outcome of the command held in the request register.
    always_comb begin
        w_status   = STAT_OK;
        w_chan     = '0;
        w_ev       = 1'b0;
        w_alloc_ok = 1'b0;
        w_ld_val   = r_ch;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_cnt < CNTW'(NCH) && w_idle_found) begin
                    w_alloc_ok        = 1'b1;
                    w_chan            = CW'(w_idle_id);
                    w_ld_val          = CW'(w_idle_id);
                    n_cnt             = r_cnt + CNTW'(1);
                    n_busy[w_idle_id] = 1'b1;
                end else begin
                    w_status = STAT_NO_IDLE;
                end
            end
            OP_READ: begin
                if (CNTW'(r_pos) < r_cnt) begin
                    w_ev   = 1'b1;
                    w_chan = w_slot[r_pos[IDXW-1:0]];
                end
            end
            OP_FREE, OP_UP, OP_DOWN, OP_TOP, OP_BOTTOM: begin
                if (CNTW'(r_ch) >= CNTW'(NCH)) begin
                    w_status = STAT_BAD_ID;
                end else if (r_op == OP_FREE) begin
                    n_busy[r_ch[IDXW-1:0]] = 1'b0;
                    if (w_found) begin
                        n_cnt = r_cnt - CNTW'(1);
                    end
                end
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
    end

    // An out-of-range channel never matches a slot, so the moves and the
    // free leave the list alone in that case without further gating.
    assign w_bc.en       = w_commit;
    assign w_bc.op       = r_op;
    assign w_bc.found    = w_found;
    assign w_bc.alloc_ok = w_alloc_ok;
    assign w_bc.pos      = w_fpos;
    assign w_bc.cnt      = r_cnt;
    assign w_bc.ch       = r_ch;
    assign w_bc.ld_val   = w_ld_val;

    // The chain of list cells; the ends see a zero neighbour that is never
    // selected.
    for (genvar g = 0; g < NCH; g++) begin : g_cell
        logic [CW-1:0] w_below;
        logic [CW-1:0] w_above;
        if (g == 0) begin : g_bot
            assign w_below = '0;
        end else begin : g_mid_b
            assign w_below = w_slot[g-1];
        end
        if (g == NCH - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_a
            assign w_above = w_slot[g+1];
        end
        lom_cell u_cell (
            .i_clk   (i_clk),
            .i_bc    (w_bc),
            .i_index (CNTW'(g)),
            .i_below (w_below),
            .i_above (w_above),
            .o_slot  (w_slot[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= '0;
        end else if (w_commit) begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_commit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_status <= w_status;
            r_o_chan   <= w_chan;
            r_o_ev     <= w_ev;
            r_o_cnt    <= n_cnt;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_channel_out = r_o_chan;
    assign o_entry_valid = r_o_ev;
    assign o_layer_count = r_o_cnt;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for layer_order_manager: an opening script of commands,
// then about six hundred random ones, each checked against a cycle-free model of the list.
// Depends on lom_pkg and layer_order_manager.
`timescale 1ns / 1ps

module testbench;

    import lom_pkg::*;

    // Opcode 7 has no name in the package; the block must treat it as a no-op.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_COMMANDS = 600;
    localparam int PHASE_LENGTH    = 40;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        t_status    status;
        logic [3:0] ch_out;
        logic       entry_valid;
        logic [4:0] layer_count;
    } t_layer_result;

    // One line of the opening script. Where checked_by_hand is set, the expected
    // result is the one typed into the row; otherwise the list model supplies it.
    typedef struct packed {
        logic [2:0]    op;
        logic [3:0]    ch;
        logic [3:0]    pos;
        logic [4:0]    repeats;
        logic          checked_by_hand;
        t_layer_result want;
    } t_script_row;

    localparam t_layer_result NO_CHECK = '{STAT_OK, 4'd0, 1'b0, 5'd0};

    localparam t_script_row OPENING_SCRIPT [24] = '{
        // Empty list straight after reset: reads, frees and moves find nothing.
        '{OP_READ,   4'd0,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd0}},
        '{OP_FREE,   4'd5,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd0}},
        '{OP_UP,     4'd3,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd0}},
        // Three allocations take channels 0, 1 and 2 in turn.
        '{OP_ALLOC,  4'd0,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd1}},
        '{OP_ALLOC,  4'd0,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd1, 1'b0, 5'd2}},
        '{OP_ALLOC,  4'd0,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd2, 1'b0, 5'd3}},
        // Up on the top entry and down on the bottom entry change nothing.
        '{OP_UP,     4'd2,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd3}},
        '{OP_DOWN,   4'd0,  4'd0,  5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd3}},
        '{OP_UP,     4'd0,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_DOWN,   4'd2,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_TOP,    4'd1,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_BOTTOM, 4'd1,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_READ,   4'd0,  4'd0,  5'd1,  1'b0, NO_CHECK},
        // A read beyond the end of the list reports no entry.
        '{OP_READ,   4'd0,  4'd15, 5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd3}},
        '{OP_FREE,   4'd2,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_ALLOC,  4'd0,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_UNUSED, 4'd15, 4'd15, 5'd1,  1'b1, '{STAT_OK, 4'd0, 1'b0, 5'd3}},
        // Fill the list, then one allocation too many finds no idle channel.
        '{OP_ALLOC,  4'd0,  4'd0,  5'd13, 1'b0, NO_CHECK},
        '{OP_ALLOC,  4'd0,  4'd0,  5'd1,  1'b1, '{STAT_NO_IDLE, 4'd0, 1'b0, 5'd16}},
        '{OP_READ,   4'd0,  4'd15, 5'd1,  1'b0, NO_CHECK},
        '{OP_BOTTOM, 4'd15, 4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_TOP,    4'd0,  4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_FREE,   4'd15, 4'd0,  5'd1,  1'b0, NO_CHECK},
        '{OP_READ,   4'd0,  4'd15, 5'd1,  1'b0, NO_CHECK}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [2:0] i_op = OP_ALLOC;
    logic [3:0] i_channel = 4'd0;
    logic [3:0] i_position = 4'd0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_status;
    logic [3:0] o_channel_out;
    logic       o_entry_valid;
    logic [4:0] o_layer_count;

    layer_order_manager u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_channel_out (o_channel_out),
        .o_entry_valid (o_entry_valid),
        .o_layer_count (o_layer_count)
    );

    // 4 ns period, high and low for 2 ns each.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Model of the list: the ids in drawing order, how many are listed, and
    // which channels are busy. Only entries below layer_total are meaningful.
    logic [3:0]    layer_ids [NCH];
    int unsigned   layer_total;
    logic [NCH-1:0] busy_mask;

    // Expected results in order of acceptance, kept in a small ring; the
    // driver only moves the write pointer and the checker only the read one.
    t_layer_result expected_ring [16];
    logic [3:0]    expect_wr;
    logic [3:0]    expect_rd;
    t_layer_result oldest_result;
    int            error_count;
    int            result_index;
    int            cycle_count;
    int            ready_hold;

    // Traffic shaping, changed by phase: the share of allocations and frees,
    // and whether both sides run without any idling at all.
    int            alloc_pct;
    int            free_pct;
    bit            quiet;

    task automatic flag_error(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] %s", $realtime, what);
        end
        error_count++;
    endtask

    // Idle stretch in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // Applies one command to the list model and returns the result it should give.
    function automatic t_layer_result apply_command(input logic [2:0] op,
                                                    input logic [3:0] ch,
                                                    input logic [3:0] pos);
        t_layer_result res;
        int            where;
        int            k;
        logic [3:0]    held;
        res = '{STAT_OK, 4'd0, 1'b0, 5'd0};
        where = layer_total;
        for (k = 0; k < layer_total; k++) begin
            if (layer_ids[k] == ch && where == layer_total) begin
                where = k;
            end
        end
        case (op)
            OP_ALLOC: begin
                res.status = STAT_NO_IDLE;
                if (layer_total < NCH) begin
                    for (k = 0; k < NCH; k++) begin
                        if (!busy_mask[k] && res.status == STAT_NO_IDLE) begin
                            busy_mask[k] = 1'b1;
                            layer_ids[layer_total] = k[3:0];
                            layer_total++;
                            res.ch_out = k[3:0];
                            res.status = STAT_OK;
                        end
                    end
                end
            end
            OP_READ: begin
                if (pos < layer_total) begin
                    res.entry_valid = 1'b1;
                    res.ch_out = layer_ids[pos];
                end
            end
            OP_FREE: begin
                busy_mask[ch] = 1'b0;
                if (where < layer_total) begin
                    for (k = where; k + 1 < layer_total; k++) begin
                        layer_ids[k] = layer_ids[k + 1];
                    end
                    layer_total--;
                end
            end
            OP_UP: begin
                if (where + 1 < layer_total) begin
                    held = layer_ids[where];
                    layer_ids[where] = layer_ids[where + 1];
                    layer_ids[where + 1] = held;
                end
            end
            OP_DOWN: begin
                if (where < layer_total && where > 0) begin
                    held = layer_ids[where];
                    layer_ids[where] = layer_ids[where - 1];
                    layer_ids[where - 1] = held;
                end
            end
            OP_TOP: begin
                if (where < layer_total) begin
                    for (k = where; k + 1 < layer_total; k++) begin
                        layer_ids[k] = layer_ids[k + 1];
                    end
                    layer_ids[layer_total - 1] = ch;
                end
            end
            OP_BOTTOM: begin
                if (where < layer_total) begin
                    for (k = where; k > 0; k--) begin
                        layer_ids[k] = layer_ids[k - 1];
                    end
                    layer_ids[0] = ch;
                end
            end
            default: begin
                // The unused opcode leaves everything as it is.
            end
        endcase
        res.layer_count = layer_total[4:0];
        return res;
    endfunction

    // Presents one command, waits for the transaction and records what the
    // block should answer. Valid only drops when an idle stretch is wanted, so
    // back-to-back commands keep it high and just change the payload.
    task automatic send_command(input logic [2:0] op, input logic [3:0] ch,
                                input logic [3:0] pos, input bit checked_by_hand,
                                input t_layer_result typed_want);
        int            gap;
        t_layer_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_op       <= op;
        i_channel  <= ch;
        i_position <= pos;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        predicted = apply_command(op, ch, pos);
        expected_ring[expect_wr] = checked_by_hand ? typed_want : predicted;
        expect_wr = expect_wr + 4'd1;
    endtask

    // Random command. Most of them name a listed channel or a position inside
    // the list, so that moves and reads actually do something.
    task automatic random_command(output logic [2:0] op, output logic [3:0] ch,
                                  output logic [3:0] pos);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            op = OP_ALLOC;
        end else if (roll < alloc_pct + free_pct) begin
            op = OP_FREE;
        end else if (roll < 97) begin
            op = 3'($urandom_range(int'(OP_UP), int'(OP_READ)));
        end else begin
            op = OP_UNUSED;
        end
        if (layer_total != 0 && $urandom_range(0, 9) < 8) begin
            ch = layer_ids[4'($urandom_range(0, layer_total - 1))];
        end else begin
            ch = 4'($urandom_range(0, 15));
        end
        if (layer_total != 0 && $urandom_range(0, 9) < 8) begin
            pos = 4'($urandom_range(0, layer_total - 1));
        end else begin
            pos = 4'($urandom_range(0, 15));
        end
    endtask

    // Receiving side: stalls of random length between spells of readiness.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            i_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expect_wr == expect_rd) begin
                flag_error($sformatf("result %0d arrived with nothing expected", result_index));
            end else begin
                oldest_result = expected_ring[expect_rd];
                expect_rd = expect_rd + 4'd1;
                if (o_status !== oldest_result.status) begin
                    flag_error($sformatf("result %0d: status %0d, expected %0d",
                                         result_index, o_status, oldest_result.status));
                end
                if (o_channel_out !== oldest_result.ch_out) begin
                    flag_error($sformatf("result %0d: channel_out %0d, expected %0d",
                                         result_index, o_channel_out, oldest_result.ch_out));
                end
                if (o_entry_valid !== oldest_result.entry_valid) begin
                    flag_error($sformatf("result %0d: entry_valid %0d, expected %0d",
                                         result_index, o_entry_valid,
                                         oldest_result.entry_valid));
                end
                if (o_layer_count !== oldest_result.layer_count) begin
                    flag_error($sformatf("result %0d: layer_count %0d, expected %0d",
                                         result_index, o_layer_count,
                                         oldest_result.layer_count));
                end
            end
            result_index++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("layer_order_manager: mismatch");
            $finish;
        end
    end

    initial begin
        logic [2:0] op;
        logic [3:0] ch;
        logic [3:0] pos;
        int         row;
        int         n;
        int         phase;

        layer_total = 0;
        busy_mask   = '0;
        expect_wr   = 4'd0;
        expect_rd   = 4'd0;
        error_count = 0;
        result_index = 0;
        cycle_count = 0;
        ready_hold  = 0;
        alloc_pct   = 40;
        free_pct    = 20;
        quiet       = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opening script, row by row; a row may repeat its command.
        for (row = 0; row < 24; row++) begin
            for (n = 0; n < OPENING_SCRIPT[row].repeats; n++) begin
                send_command(OPENING_SCRIPT[row].op, OPENING_SCRIPT[row].ch,
                             OPENING_SCRIPT[row].pos, OPENING_SCRIPT[row].checked_by_hand,
                             OPENING_SCRIPT[row].want);
            end
        end

        // Random part in phases that fill, drain or churn the list, so that
        // the length sweeps the whole range from empty to full again and again.
        for (n = 0; n < RANDOM_COMMANDS; n++) begin
            if (n % PHASE_LENGTH == 0) begin
                phase = $urandom_range(0, 2);
                alloc_pct = (phase == 0) ? 60 : (phase == 1) ? 10 : 25;
                free_pct  = (phase == 0) ? 10 : (phase == 1) ? 50 : 25;
                quiet = ($urandom_range(0, 4) == 0);
            end
            random_command(op, ch, pos);
            send_command(op, ch, pos, 1'b0, NO_CHECK);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        quiet = 1'b0;

        while (expect_wr != expect_rd) begin
            @(posedge i_clk);
        end
        // Run on past the last result so that a stray extra result would still be seen.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("layer_order_manager: match");
        end else begin
            $display("layer_order_manager: mismatch");
        end
        $finish;
    end

endmodule
